### rtl/core/binary_dead_end_pruner_assert.svh
// Assertion macros used by the dead-end pruner checker.
`ifndef BINARY_DEAD_END_PRUNER_ASSERT_SVH
`define BINARY_DEAD_END_PRUNER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define BDEP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bdep assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define BDEP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bdep assertion failed");

`endif

### rtl/core/bdep_pkg.sv
// Shared constants for the binary dead-end pruner.
`default_nettype none
package bdep_pkg;
   localparam int ROW_BITS = 64;
   localparam int COL_BITS = $clog2(ROW_BITS);
   localparam int CFG_BITS = 7;
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;
endpackage
`default_nettype wire

### rtl/core/bdep_ram.sv
// Generic simple dual-port RAM with registered read; read data holds between reads.
`default_nettype none
module bdep_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/core/binary_dead_end_pruner.sv
// Binary dead-end pruner: loads an image row by row, prunes spurs bit-serially, emits rows.
// After the last row, the block sweeps the image again and again until a sweep clears
// nothing; then it emits the rows one after another, held by any output stall.
// Throughput: one input row per cycle while loading; the next image loads only after the
// last row of the previous one has gone out. Bit-serial sweep over 64 columns sets the pace.
// Reset (synchronous, active high): registers return to 64 x 64, load count to zero, no output.
`default_nettype none
module binary_dead_end_pruner #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input rows
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [bdep_pkg::ROW_BITS-1:0]       req_row_pixels,
   // output rows
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [bdep_pkg::ROW_BITS-1:0]       rsp_pruned_row,
   output logic                                     rsp_last_row,
   // configuration
   input  wire logic                                csr_wr_en,
   input  wire logic [bdep_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [bdep_pkg::CFG_BITS-1:0]       csr_wdata
);
   localparam int RB = bdep_pkg::ROW_BITS;
   localparam int CB = bdep_pkg::CFG_BITS;
   localparam int XB = bdep_pkg::COL_BITS;
   localparam int AW = $clog2(MAX_HEIGHT);
   localparam int YW = $clog2(MAX_HEIGHT + 1);
   localparam int HW = (YW > CB) ? YW : CB;

   typedef enum logic [3:0] {
      S_LOAD,
      S_PRE0,
      S_PRE1,
      S_PRE2,
      S_PRE3,
      S_ROW,
      S_NEXT,
      S_OUT_RD,
      S_OUT_WAIT,
      S_OUT_SEND
   } state_type;

   // control
   state_type        state_ff, state_in;
   logic [CB-1:0]    width_ff, width_in;
   logic [CB-1:0]    height_ff, height_in;
   logic [YW-1:0]    loaded_ff, loaded_in;
   logic [YW-1:0]    y_ff, y_in;
   logic [XB-1:0]    x_ff, x_in;
   logic             changed_ff, changed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   // payload
   logic [RB-1:0]    up_sr_ff, up_sr_in;
   logic [RB-1:0]    cur_sr_ff, cur_sr_in;
   logic [RB-1:0]    dn_sr_ff, dn_sr_in;
   logic             left_ff, left_in;
   logic [RB-1:0]    rsp_row_ff, rsp_row_in;
   logic             rsp_last_ff, rsp_last_in;

   // row store
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [RB-1:0]    ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [RB-1:0]    ram_rd_data;

   // effective dimensions
   logic [CB-1:0]    w_eff;
   logic [HW-1:0]    h_wide;
   logic [HW-1:0]    h_clamp;
   logic [YW-1:0]    h_eff;
   logic [RB-1:0]    col_mask;

   // pixel rule
   logic             pix_c, pix_u, pix_d, pix_l, pix_r;
   logic [2:0]       nbr_cnt;
   logic             interior;
   logic             clear_bit;
   logic             new_bit;
   logic [YW:0]      y_plus2;
   logic [YW:0]      y_plus1;
   logic             req_fire;

   bdep_ram #(
      .WIDTH (RB),
      .DEPTH (MAX_HEIGHT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Clamp the registers into 3..MAX.
   always_comb begin
      if (width_ff < CB'(3)) begin
         w_eff = CB'(3);
      end else if (width_ff > CB'(MAX_WIDTH)) begin
         w_eff = CB'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_wide = HW'(height_ff);
      if (h_wide < HW'(3)) begin
         h_clamp = HW'(3);
      end else if (h_wide > HW'(MAX_HEIGHT)) begin
         h_clamp = HW'(MAX_HEIGHT);
      end else begin
         h_clamp = h_wide;
      end
      h_eff = h_clamp[YW-1:0];
      for (int i = 0; i < RB; i++) begin
         col_mask[i] = (CB'(i) < w_eff);
      end
   end

   // One pixel per cycle: bit 0 of the window registers is column x_ff. The left
   // neighbour is the value just written back, the right one still the old value.
   always_comb begin
      pix_c     = cur_sr_ff[0];
      pix_r     = cur_sr_ff[1];
      pix_u     = up_sr_ff[0];
      pix_d     = dn_sr_ff[0];
      pix_l     = left_ff;
      nbr_cnt   = 3'(pix_u) + 3'(pix_l) + 3'(pix_r) + 3'(pix_d);
      interior  = (x_ff != '0) && ((CB'(x_ff) + CB'(2)) <= w_eff);
      clear_bit = pix_c && interior && (nbr_cnt == 3'd1);
      new_bit   = pix_c && !clear_bit;
   end

   assign y_plus2  = {1'b0, y_ff} + (YW + 1)'(2);
   assign y_plus1  = {1'b0, y_ff} + (YW + 1)'(1);
   assign req_fire = req_valid && (state_ff == S_LOAD);

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      loaded_in    = loaded_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      changed_in   = changed_ff;
      rsp_valid_in = rsp_valid_ff;
      up_sr_in     = up_sr_ff;
      cur_sr_in    = cur_sr_ff;
      dn_sr_in     = dn_sr_ff;
      left_in      = left_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = loaded_ff[AW-1:0];
      ram_wr_data  = req_row_pixels & col_mask;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = y_ff[AW-1:0];

      case (state_ff)
         S_LOAD: begin
            // Store the row, masked to the width in use; start sweeping on the last one.
            if (req_fire) begin
               ram_wr_en = 1'b1;
               if (loaded_ff + YW'(1) == h_eff) begin
                  loaded_in = '0;
                  state_in  = S_PRE0;
               end else begin
                  loaded_in = loaded_ff + YW'(1);
               end
            end
         end
         S_PRE0: begin
            changed_in  = 1'b0;
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(0);
            state_in    = S_PRE1;
         end
         S_PRE1: begin
            up_sr_in    = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(1);
            state_in    = S_PRE2;
         end
         S_PRE2: begin
            cur_sr_in   = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(2);
            state_in    = S_PRE3;
         end
         S_PRE3: begin
            dn_sr_in = ram_rd_data;
            y_in     = YW'(1);
            x_in     = '0;
            state_in = S_ROW;
         end
         S_ROW: begin
            // Rotate all three rows; the current row takes the updated bit at the top.
            up_sr_in   = {up_sr_ff[0], up_sr_ff[RB-1:1]};
            dn_sr_in   = {dn_sr_ff[0], dn_sr_ff[RB-1:1]};
            cur_sr_in  = {new_bit, cur_sr_ff[RB-1:1]};
            left_in    = new_bit;
            changed_in = changed_ff || clear_bit;
            x_in       = x_ff + XB'(1);
            // Prefetch the row that slides in below next.
            if ((x_ff == '0) && (y_plus2 < {1'b0, h_eff})) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = y_plus2[AW-1:0];
            end
            if (x_ff == XB'(RB - 1)) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            // Write back the finished row and slide the window down by one.
            ram_wr_en   = 1'b1;
            ram_wr_addr = y_ff[AW-1:0];
            ram_wr_data = cur_sr_ff;
            up_sr_in    = cur_sr_ff;
            cur_sr_in   = dn_sr_ff;
            dn_sr_in    = ram_rd_data;
            x_in        = '0;
            if (y_plus2 == {1'b0, h_eff}) begin
               if (changed_ff) begin
                  state_in = S_PRE0;
               end else begin
                  y_in     = '0;
                  state_in = S_OUT_RD;
               end
            end else begin
               y_in     = y_plus1[YW-1:0];
               state_in = S_ROW;
            end
         end
         S_OUT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = y_ff[AW-1:0];
            state_in    = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            rsp_row_in   = ram_rd_data;
            rsp_last_in  = (y_plus1 == {1'b0, h_eff});
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_SEND;
         end
         S_OUT_SEND: begin
            // Hold the transaction until the receiver takes it.
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_LOAD;
               end else begin
                  y_in     = y_plus1[YW-1:0];
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // Register writes restart the load.
      if (csr_wr_en) begin
         case (csr_index)
            bdep_pkg::CSR_IMAGE_WIDTH: begin
               width_in  = csr_wdata;
               loaded_in = '0;
            end
            bdep_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               loaded_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      up_sr_ff    <= up_sr_in;
      cur_sr_ff   <= cur_sr_in;
      dn_sr_ff    <= dn_sr_in;
      left_ff     <= left_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
      y_ff        <= y_in;
      x_ff        <= x_in;
      if (reset) begin
         state_ff     <= S_LOAD;
         width_ff     <= CB'(64);
         height_ff    <= CB'(64);
         loaded_ff    <= '0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         loaded_ff    <= loaded_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall      = (state_ff != S_LOAD);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pruned_row = rsp_row_ff;
   assign rsp_last_row   = rsp_last_ff;
endmodule
`default_nettype wire

### rtl/core/bdep_checker.sv
// Port-level checker for the binary dead-end pruner, bound to the top level.
`default_nettype none
`include "binary_dead_end_pruner_assert.svh"
module bdep_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [bdep_pkg::ROW_BITS-1:0] rsp_pruned_row,
   input wire logic                          rsp_last_row
);
   // A stalled result transaction holds.
   `BDEP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pruned_row) && $stable(rsp_last_row))
   // No input transaction is taken while a result is pending.
   `BDEP_ASSERT_NOW(a_no_load_during_out, rsp_valid, req_stall)
   // After the last row goes out the output drops and loading resumes.
   `BDEP_ASSERT_NEXT(a_last_ends_image, rsp_valid && rsp_last_row && !rsp_stall, !rsp_valid && !req_stall)
   // Leaving reset, the block is ready to load with no output.
   `BDEP_ASSERT_NOW(a_reset_state, $past(reset), !rsp_valid && !req_stall)
   // While an input transaction is taken, no result is pending.
   `BDEP_ASSERT_NOW(a_idle_accepts, !req_stall && req_valid, !rsp_valid)
endmodule

bind binary_dead_end_pruner bdep_checker u_bdep_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pruned_row (rsp_pruned_row),
   .rsp_last_row   (rsp_last_row)
);
`default_nettype wire

### dv/binary_dead_end_pruner_tb.sv
// Self-checking testbench for the binary dead-end pruner: random images, idling, stalls.
`timescale 1ns / 1ps
module binary_dead_end_pruner_tb;

   localparam int ROW_BITS      = bdep_pkg::ROW_BITS;
   localparam int CFG_BITS      = bdep_pkg::CFG_BITS;
   localparam int CSR_IDX_BITS  = bdep_pkg::CSR_IDX_BITS;

   localparam int FRAME_MAX_W   = 64;
   localparam int FRAME_MAX_H   = 64;
   localparam int RANDOM_ROWS   = 395;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 400;
   // Every sweep but the last clears at least one interior pixel, so one image never
   // needs more than (interior pixels + 1) sweeps.
   localparam int unsigned SWEEP_CYCLES = 4 + 65 * (FRAME_MAX_H - 2);
   localparam int unsigned MAX_SWEEPS   = (FRAME_MAX_W - 2) * (FRAME_MAX_H - 2) + 1;
   localparam int unsigned QUIET_LIMIT  = 2 * SWEEP_CYCLES * MAX_SWEEPS;
   // Index with no register behind it; a write there must leave the load alone.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic [ROW_BITS-1:0] pixels;
      logic                last;
   } pruned_row_type;

   typedef enum int {FILL_NOISE, FILL_SPARSE, FILL_DENSE, FILL_CORRIDOR} fill_style_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [ROW_BITS-1:0]     req_row_pixels = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [ROW_BITS-1:0]     rsp_pruned_row;
   logic                    rsp_last_row;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]     csr_wdata = '0;

   binary_dead_end_pruner #(
      .MAX_WIDTH (FRAME_MAX_W),
      .MAX_HEIGHT(FRAME_MAX_H)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row_pixels(req_row_pixels),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pruned_row(rsp_pruned_row),
      .rsp_last_row  (rsp_last_row),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction: a private copy of the register file and the row store.
   // ---------------------------------------------------------------------------------------
   logic [CFG_BITS-1:0] cfg_width  = 7'd64;
   logic [CFG_BITS-1:0] cfg_height = 7'd64;
   logic [ROW_BITS-1:0] frame_rows [FRAME_MAX_H];
   int unsigned         rows_in_frame = 0;

   logic [ROW_BITS-1:0] row_queue [$];    // rows waiting for the driver
   pruned_row_type      rows_due [$];     // pruned rows the block still owes

   int unsigned fail_count   = 0;
   int unsigned rows_in      = 0;
   int unsigned rows_out     = 0;
   int unsigned images_done  = 0;
   int unsigned max_sweeps   = 0;
   int unsigned reg_writes   = 0;

   // Out-of-range register values act as the nearest legal size.
   function automatic int unsigned bounded_size(input logic [CFG_BITS-1:0] raw,
                                                input int unsigned hi);
      if (raw < 3) return 3;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic logic [ROW_BITS-1:0] column_mask(input int unsigned w);
      if (w >= ROW_BITS) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   // Sweep the interior in raster order, clearing open pixels with exactly one open
   // neighbor in place, until a sweep clears nothing. Return the number of sweeps.
   function automatic int unsigned fold_spurs(input int unsigned w, input int unsigned h);
      int unsigned sweeps;
      int unsigned r;
      int unsigned c;
      int unsigned n;
      bit          cleared_any;
      sweeps = 0;
      do begin
         cleared_any = 1'b0;
         sweeps++;
         for (r = 1; r + 1 < h; r++) begin
            for (c = 1; c + 1 < w; c++) begin
               if (frame_rows[r][c]) begin
                  n = int'(frame_rows[r-1][c]) + int'(frame_rows[r][c-1]) +
                      int'(frame_rows[r][c+1]) + int'(frame_rows[r+1][c]);
                  if (n == 1) begin
                     frame_rows[r][c] = 1'b0;
                     cleared_any = 1'b1;
                  end
               end
            end
         end
      end while (cleared_any);
      return sweeps;
   endfunction

   // Store one accepted row; on the last row of the image, prune and queue every row.
   function automatic void absorb_row(input logic [ROW_BITS-1:0] pixels);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned sweeps;
      pruned_row_type due;
      w = bounded_size(cfg_width, FRAME_MAX_W);
      h = bounded_size(cfg_height, FRAME_MAX_H);
      if (rows_in_frame >= h) rows_in_frame = 0;
      frame_rows[rows_in_frame] = pixels & column_mask(w);
      rows_in_frame++;
      if (rows_in_frame < h) return;
      sweeps = fold_spurs(w, h);
      if (sweeps > max_sweeps) max_sweeps = sweeps;
      for (r = 0; r < h; r++) begin
         due.pixels = frame_rows[r];
         due.last   = (r + 1 == h);
         rows_due.push_back(due);
      end
      rows_in_frame = 0;
      images_done++;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: presents queued rows in bursts with random gaps, holds a row while stalled.
   // ---------------------------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_row(req_row_pixels);
            rows_in++;
         end
         // Advance only when the current transaction is gone (or there is none).
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || row_queue.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid      <= 1'b1;
               req_row_pixels <= row_queue.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // Half the bursts run back to back, the rest leave a short hole.
                  burst_left = $urandom_range(1, 24);
                  gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: check each accepted row against the oldest expectation; drive the stall.
   // ---------------------------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_tick = 0;

   always @(posedge clock) begin : row_monitor
      pruned_row_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rows_out++;
            if (rows_due.size() == 0) begin
               $error("pruned_row with no row expected: got %h (last_row %b)",
                      rsp_pruned_row, rsp_last_row);
               fail_count++;
            end else begin
               due = rows_due.pop_front();
               if (rsp_pruned_row !== due.pixels) begin
                  $error("pruned_row mismatch: expected %h, got %h", due.pixels, rsp_pruned_row);
                  fail_count++;
               end
               if (rsp_last_row !== due.last) begin
                  $error("last_row mismatch: expected %b, got %b", due.last, rsp_last_row);
                  fail_count++;
               end
            end
         end
         // Switch stall pattern every so often so that quiet stretches alternate with heavy ones.
         stall_tick++;
         if (stall_tick >= 97) begin
            stall_tick = 0;
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_stall <= (stall_tick % 4 != 0);
            default:        rsp_stall <= ($urandom_range(0, 15) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves a transaction for too long.
   // ---------------------------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("binary_dead_end_pruner verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   // Write one register; mirror it at the edge on which the block takes the write.
   task automatic program_reg(input logic [CSR_IDX_BITS-1:0] idx,
                              input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         bdep_pkg::CSR_IMAGE_WIDTH: begin
            cfg_width     = value;
            rows_in_frame = 0;
         end
         bdep_pkg::CSR_IMAGE_HEIGHT: begin
            cfg_height    = value;
            rows_in_frame = 0;
         end
         default: ;
      endcase
      reg_writes++;
   endtask

   // Hold until nothing is queued, presented or owed, then settle and confirm.
   task automatic wait_idle();
      bit settled;
      settled = 1'b0;
      while (!settled) begin
         @(posedge clock);
         if (row_queue.size() == 0 && !req_valid && rows_due.size() == 0) begin
            repeat (SETTLE_CYCLES) @(posedge clock);
            settled = (row_queue.size() == 0 && !req_valid && rows_due.size() == 0);
         end
      end
   endtask

   // Corridor style gives dense odd-free horizontal runs joined by sparse verticals,
   // which leaves plenty of dead ends.
   function automatic logic [ROW_BITS-1:0] draw_row(input fill_style_type style,
                                                    input int unsigned r);
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case (style)
         FILL_SPARSE:   return a & b;
         FILL_DENSE:    return a | b;
         FILL_CORRIDOR: return r[0] ? (a & b & {$urandom, $urandom}) : (a | b);
         default:       return a;
      endcase
   endfunction

   initial begin : stimulus
      int unsigned         random_rows;
      int unsigned         big_left;
      int unsigned         w;
      int unsigned         h;
      int unsigned         images;
      int unsigned         partial;
      int unsigned         i;
      int unsigned         r;
      bit                  first_phase;
      fill_style_type      style;
      logic [CFG_BITS-1:0] wraw;
      logic [CFG_BITS-1:0] hraw;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // Two rows of a default-size image, then a register write must throw them away.
      row_queue.push_back('1);
      row_queue.push_back('0);
      wait_idle();
      program_reg(bdep_pkg::CSR_IMAGE_WIDTH, 7'd3);
      program_reg(bdep_pkg::CSR_IMAGE_HEIGHT, 7'd3);

      // Smallest image, fully open; bits beyond the width must vanish.
      repeat (3) row_queue.push_back('1);
      wait_idle();

      // Sizes below the minimum act as 3; centre pixel with one neighbor goes away,
      // last row carries only bits beyond the width.
      program_reg(bdep_pkg::CSR_IMAGE_WIDTH, 7'd0);
      program_reg(bdep_pkg::CSR_IMAGE_HEIGHT, 7'd2);
      row_queue.push_back(64'h2);
      row_queue.push_back(64'h2);
      row_queue.push_back(64'hFFFF_FFFF_FFFF_FFF8);
      wait_idle();

      // A write to an index with no register, mid-image, must not restart the load.
      row_queue.push_back('0);
      wait_idle();
      program_reg(CSR_SPARE_INDEX, 7'h7F);
      row_queue.push_back(64'h2);
      row_queue.push_back(64'h2);
      wait_idle();

      // Widest setting (127 acts as 64): a spur ending low (one pixel per sweep), one
      // ending high (gone in one sweep), a lone pixel, a free segment, a junction.
      program_reg(bdep_pkg::CSR_IMAGE_WIDTH, 7'd127);
      program_reg(bdep_pkg::CSR_IMAGE_HEIGHT, 7'd6);
      row_queue.push_back(~(64'd1 << 30));
      row_queue.push_back((64'd1 << 5) | (64'd1 << 30) | (64'd1 << 60));
      row_queue.push_back((64'd1 << 5) | (64'd1 << 30) | (64'd1 << 50) | (64'd7 << 59));
      row_queue.push_back((64'd1 << 5) | (64'd1 << 30) | (64'h3F << 40) | (64'd1 << 60));
      row_queue.push_back((64'd1 << 5) | (64'd1 << 30));
      row_queue.push_back((64'd1 << 30) | (64'd1 << 63) | 64'd1);
      wait_idle();

      // Full width, all closed then all open.
      program_reg(bdep_pkg::CSR_IMAGE_WIDTH, 7'd64);
      program_reg(bdep_pkg::CSR_IMAGE_HEIGHT, 7'd3);
      repeat (3) row_queue.push_back('0);
      repeat (3) row_queue.push_back('1);
      wait_idle();

      // --- random part ---
      // Each phase: new sizes, a few whole images, sometimes a trailing partial image
      // that the next phase's register write discards. Sender pauses between phases.
      random_rows = 0;
      big_left    = 2;
      first_phase = 1'b1;
      while (random_rows < RANDOM_ROWS) begin
         case ($urandom_range(0, 4))
            0:       wraw = CFG_BITS'($urandom_range(0, 2));
            1:       wraw = CFG_BITS'($urandom_range(3, 20));
            2:       wraw = CFG_BITS'($urandom_range(21, 63));
            3:       wraw = 7'd64;
            default: wraw = CFG_BITS'($urandom_range(65, 127));
         endcase
         if (big_left > 0 && $urandom_range(0, 11) == 0) begin
            hraw = CFG_BITS'($urandom_range(40, 127));
            big_left--;
         end else if ($urandom_range(0, 5) == 0) begin
            hraw = CFG_BITS'($urandom_range(0, 2));
         end else begin
            hraw = CFG_BITS'($urandom_range(3, 10));
         end
         if (first_phase) begin
            // Largest image once for certain.
            wraw = 7'd64;
            hraw = 7'd64;
         end

         if (!first_phase && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) program_reg(bdep_pkg::CSR_IMAGE_WIDTH, wraw);
            else program_reg(bdep_pkg::CSR_IMAGE_HEIGHT, hraw);
         end else if ($urandom_range(0, 1)) begin
            program_reg(bdep_pkg::CSR_IMAGE_WIDTH, wraw);
            program_reg(bdep_pkg::CSR_IMAGE_HEIGHT, hraw);
         end else begin
            program_reg(bdep_pkg::CSR_IMAGE_HEIGHT, hraw);
            program_reg(bdep_pkg::CSR_IMAGE_WIDTH, wraw);
         end
         first_phase = 1'b0;

         w = bounded_size(cfg_width, FRAME_MAX_W);
         h = bounded_size(cfg_height, FRAME_MAX_H);
         images = (h > 16) ? 1 : $urandom_range(1, 4);
         style  = fill_style_type'($urandom_range(0, 3));
         for (i = 0; i < images; i++) begin
            for (r = 0; r < h; r++) begin
               row_queue.push_back(draw_row(style, r));
               random_rows++;
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            partial = $urandom_range(1, h - 1);
            for (r = 0; r < partial; r++) begin
               row_queue.push_back(draw_row(style, r));
               random_rows++;
            end
         end
         wait_idle();
      end

      // Hold a while in case the block emits anything it does not owe.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d images from %0d rows in, %0d rows out, %0d register writes",
               images_done, rows_in, rows_out, reg_writes);
      $display("sizes 3 to 64 in both directions, up to %0d sweeps per image", max_sweeps);
      if (fail_count == 0) begin
         $display("binary_dead_end_pruner verification clean");
      end else begin
         $display("binary_dead_end_pruner verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/bdep_pkg.sv
rtl/core/bdep_ram.sv
rtl/core/binary_dead_end_pruner.sv
rtl/core/bdep_checker.sv
dv/binary_dead_end_pruner_tb.sv
